// ===== hdl/mqtt_inbound_packet_deframer_unit_assert.svh =====
// Assertion macros for the deframer's port-level checker.
`ifndef MQTT_INBOUND_PACKET_DEFRAMER_UNIT_ASSERT_SVH
`define MQTT_INBOUND_PACKET_DEFRAMER_UNIT_ASSERT_SVH

// Clocked on clk_i, off while rst_ni is low.
`define MQTTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked on clk_i, checked during reset too.
`define MQTTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/mqttd_pkg.sv =====
// Types, codes and constants of the MQTT inbound packet deframer.
package mqttd_pkg;

  localparam int unsigned AckCountWidth = 16;

  localparam logic [3:0] PublishType  = 4'h3;
  localparam logic [7:0] ConnackByte  = 8'h20;
  localparam logic [7:0] SubackByte   = 8'h90;
  localparam logic [7:0] PubackByte   = 8'h40;
  localparam logic [7:0] LenContFlag  = 8'h80;

  // remaining-length limit is 4 bytes of 7 bits
  localparam int unsigned LenWidth    = 28;
  localparam logic [LenWidth-1:0] PidBytes = LenWidth'(4);

  typedef enum logic [9:0] {
    PhIdle  = 10'b00_0000_0001,
    PhLen   = 10'b00_0000_0010,
    PhThi   = 10'b00_0000_0100,
    PhTlo   = 10'b00_0000_1000,
    PhTopic = 10'b00_0001_0000,
    PhPidh  = 10'b00_0010_0000,
    PhPidl  = 10'b00_0100_0000,
    PhPay   = 10'b00_1000_0000,
    PhAck   = 10'b01_0000_0000,
    PhDrop  = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    EvTopic      = 3'd0,
    EvPayload    = 3'd1,
    EvEmpty      = 3'd2,
    EvConnack    = 3'd3,
    EvSuback     = 3'd4,
    EvPuback     = 3'd5,
    EvUnparsable = 3'd6,
    EvMalformed  = 3'd7
  } event_kind_e;

  typedef enum logic [1:0] {
    AckConnack = 2'd0,
    AckSuback  = 2'd1,
    AckPuback  = 2'd2
  } ack_kind_e;

  typedef struct packed {
    logic      inc;
    ack_kind_e kind;
  } tally_req_t;

  typedef struct packed {
    logic        valid;
    event_kind_e kind;
    logic [7:0]  data;
    logic        msg_end;
  } step_res_t;

endpackage

// ===== hdl/mqtt_inbound_packet_deframer_unit.sv =====
// Top level of the MQTT inbound packet deframer: input register, parser, result register.
// A byte waits in the input register until the single-pass parser between the two registers
// takes it; it takes one byte per cycle unless a stalled result slot holds the flow.
// Reset (rst_ni low, asynchronous): phase to idle, counters and tallies to zero, both
// valid flags cleared.
module mqtt_inbound_packet_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        chunk_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  out_byte_o,
  output logic        message_end_o,
  output logic [15:0] ack_total_o
);
  import mqttd_pkg::*;

  // Input register: holds one byte so the parser sees registered data.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       ce_q;

  // Result register.
  logic        out_valid_q, out_valid_d;
  event_kind_e kind_q;
  logic [7:0]  data_q;
  logic        end_q;
  logic [15:0] total_q;

  logic       adv;      // result register free, or emptied this cycle
  logic       step;     // parser consumes the held byte
  logic       in_xfer;  // input transfer completes

  step_res_t  res;
  tally_req_t treq;
  logic [15:0] tally_total;

  assign adv        = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  // A parsed byte that gives no result still frees the slot.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = res.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  mqttd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (byte_q),
    .chunk_end_i (ce_q),
    .res_o       (res),
    .tally_o     (treq)
  );

  mqttd_tally u_tally (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (treq),
    .total_o (tally_total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= rx_byte_i;
      ce_q   <= chunk_end_i;
    end
  end

  // Ack total is nonzero only on acknowledge events.
  always_ff @(posedge clk_i) begin
    if (step && res.valid) begin
      kind_q  <= res.kind;
      data_q  <= res.data;
      end_q   <= res.msg_end;
      total_q <= treq.inc ? tally_total : 16'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_kind_o  = kind_q;
  assign out_byte_o    = data_q;
  assign message_end_o = end_q;
  assign ack_total_o   = total_q;

endmodule

// ===== hdl/mqttd_tally.sv =====
// Wrapping counters for CONNACK, SUBACK and PUBACK packets.
module mqttd_tally (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mqttd_pkg::tally_req_t  req_i,
  output logic [15:0]            total_o
);
  import mqttd_pkg::*;

  logic [AckCountWidth-1:0] connack_q, connack_d;
  logic [AckCountWidth-1:0] suback_q, suback_d;
  logic [AckCountWidth-1:0] puback_q, puback_d;
  logic [AckCountWidth-1:0] sel, sel_next;

  always_comb begin
    unique case (req_i.kind)
      AckConnack: sel = connack_q;
      AckSuback:  sel = suback_q;
      default:    sel = puback_q;
    endcase
    sel_next  = sel + AckCountWidth'(1);
    connack_d = connack_q;
    suback_d  = suback_q;
    puback_d  = puback_q;
    if (req_i.inc) begin
      unique case (req_i.kind)
        AckConnack: connack_d = sel_next;
        AckSuback:  suback_d  = sel_next;
        default:    puback_d  = sel_next;
      endcase
    end
  end

  // low 16 bits of the updated count, zero-extended for narrow counters
  assign total_o = 16'(sel_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connack_q <= '0;
      suback_q  <= '0;
      puback_q  <= '0;
    end else begin
      connack_q <= connack_d;
      suback_q  <= suback_d;
      puback_q  <= puback_d;
    end
  end

endmodule

// ===== hdl/mqttd_parse.sv =====
// Per-byte packet parser: phase, length and topic counters, one byte a cycle while step_i is high.
module mqttd_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   chunk_end_i,
  output mqttd_pkg::step_res_t   res_o,
  output mqttd_pkg::tally_req_t  tally_o
);
  import mqttd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [LenWidth-1:0] acc_q, acc_d;
  logic [2:0]          idx_q, idx_d;
  logic [LenWidth-1:0] rem_q, rem_d;
  logic [15:0]         topic_q, topic_d;
  logic [2:0]          ack_left_q, ack_left_d;
  ack_kind_e           ack_kind_q, ack_kind_d;

  logic [LenWidth-1:0] len_part;
  logic [15:0]         tlen_full;
  logic [LenWidth:0]   topic_need;
  step_res_t           res;
  tally_req_t          treq;

  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    len_part = LenWidth'(rx_byte_i[6:0]);
      2'd1:    len_part = LenWidth'({rx_byte_i[6:0], 7'b0});
      2'd2:    len_part = LenWidth'({rx_byte_i[6:0], 14'b0});
      default: len_part = LenWidth'({rx_byte_i[6:0], 21'b0});
    endcase
    tlen_full  = {topic_q[15:8], rx_byte_i};
    topic_need = (LenWidth+1)'(tlen_full) + (LenWidth+1)'(PidBytes);
  end

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    idx_d      = idx_q;
    rem_d      = rem_q;
    topic_d    = topic_q;
    ack_left_d = ack_left_q;
    ack_kind_d = ack_kind_q;
    res        = '0;
    treq       = '0;
    treq.kind  = ack_kind_q;

    unique case (phase_q)
      PhLen: begin
        acc_d = acc_q + len_part;
        idx_d = idx_q + 3'd1;
        if (rx_byte_i < LenContFlag || idx_q[1:0] == 2'd3) begin
          phase_d = PhThi;
        end
      end
      PhThi: begin
        topic_d = {rx_byte_i, 8'h00};
        phase_d = PhTlo;
      end
      PhTlo: begin
        topic_d = tlen_full;
        if (topic_need > {1'b0, acc_q}) begin
          res.valid = 1'b1;
          res.kind  = EvMalformed;
          phase_d   = chunk_end_i ? PhIdle : PhDrop;
        end else begin
          rem_d   = acc_q - PidBytes - LenWidth'(tlen_full);
          phase_d = (tlen_full != 16'd0) ? PhTopic : PhPidh;
        end
      end
      PhTopic: begin
        topic_d       = topic_q - 16'd1;
        res.valid     = 1'b1;
        res.kind      = EvTopic;
        res.data      = rx_byte_i;
        res.msg_end   = (topic_q == 16'd1) && (rem_q == '0);
        if (topic_q == 16'd1) begin
          phase_d = PhPidh;
        end
      end
      PhPidh: phase_d = PhPidl;
      PhPidl: begin
        if (rem_q != '0) begin
          phase_d = PhPay;
        end else begin
          phase_d = PhIdle;
          if (acc_q == PidBytes) begin
            res.valid   = 1'b1;
            res.kind    = EvEmpty;
            res.msg_end = 1'b1;
          end
        end
      end
      PhPay: begin
        rem_d       = rem_q - LenWidth'(1);
        res.valid   = 1'b1;
        res.kind    = EvPayload;
        res.data    = rx_byte_i;
        res.msg_end = (rem_q == LenWidth'(1));
        if (rem_q == LenWidth'(1)) begin
          phase_d = PhIdle;
        end
      end
      PhAck: begin
        ack_left_d = ack_left_q - 3'd1;
        if (ack_left_q == 3'd1) begin
          phase_d   = PhIdle;
          treq.inc  = 1'b1;
          res.valid = 1'b1;
          unique case (ack_kind_q)
            AckConnack: res.kind = EvConnack;
            AckSuback:  res.kind = EvSuback;
            default:    res.kind = EvPuback;
          endcase
        end
      end
      PhDrop: begin
        if (chunk_end_i) begin
          phase_d = PhIdle;
        end
      end
      default: begin
        // idle, and any code that is not a valid phase
        if (rx_byte_i[7:4] == PublishType) begin
          acc_d   = '0;
          idx_d   = '0;
          phase_d = PhLen;
        end else if (rx_byte_i == ConnackByte || rx_byte_i == SubackByte ||
                     rx_byte_i == PubackByte) begin
          if (rx_byte_i == ConnackByte) begin
            ack_kind_d = AckConnack;
          end else if (rx_byte_i == SubackByte) begin
            ack_kind_d = AckSuback;
          end else begin
            ack_kind_d = AckPuback;
          end
          ack_left_d = (rx_byte_i == SubackByte) ? 3'd4 : 3'd3;
          phase_d    = PhAck;
        end else begin
          res.valid = 1'b1;
          res.kind  = EvUnparsable;
          phase_d   = chunk_end_i ? PhIdle : PhDrop;
        end
      end
    endcase
  end

  assign res_o   = step_i ? res : '0;
  assign tally_o = '{inc: step_i & treq.inc, kind: treq.kind};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      acc_q      <= '0;
      idx_q      <= '0;
      rem_q      <= '0;
      topic_q    <= '0;
      ack_left_q <= '0;
      ack_kind_q <= AckConnack;
    end else if (step_i) begin
      phase_q    <= phase_d;
      acc_q      <= acc_d;
      idx_q      <= idx_d;
      rem_q      <= rem_d;
      topic_q    <= topic_d;
      ack_left_q <= ack_left_d;
      ack_kind_q <= ack_kind_d;
    end
  end

endmodule

// ===== hdl/mqttd_checker.sv =====
// Port-level checker for the deframer, bound to the top level.
`include "mqtt_inbound_packet_deframer_unit_assert.svh"

module mqttd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_kind_o,
  input logic [7:0]  out_byte_o,
  input logic        message_end_o,
  input logic [15:0] ack_total_o
);
  import mqttd_pkg::*;

  `MQTTD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")
  `MQTTD_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable({event_kind_o, out_byte_o, message_end_o, ack_total_o}), "result changed while stalled")
  `MQTTD_ASSERT(a_ready_free, !out_valid_o |-> in_ready_o, "input stalled with empty result slot")
  `MQTTD_ASSERT(a_ack_fields, out_valid_o && (event_kind_o == EvConnack || event_kind_o == EvSuback || event_kind_o == EvPuback) |-> !message_end_o && out_byte_o == 8'd0, "ack event carries data")
  `MQTTD_ASSERT(a_nonack_total, out_valid_o && (event_kind_o == EvTopic || event_kind_o == EvPayload || event_kind_o == EvEmpty || event_kind_o == EvUnparsable || event_kind_o == EvMalformed) |-> ack_total_o == 16'd0, "ack total on non-ack event")

endmodule

bind mqtt_inbound_packet_deframer_unit mqttd_checker u_mqttd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .event_kind_o  (event_kind_o),
  .out_byte_o    (out_byte_o),
  .message_end_o (message_end_o),
  .ack_total_o   (ack_total_o)
);

// ===== dv/mqtt_inbound_packet_deframer_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the MQTT inbound packet deframer: random byte streams, scoreboard.
module mqtt_inbound_packet_deframer_unit_test;
  import mqttd_pkg::*;

  // One received byte as offered to the block.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } rx_item_t;

  // One deframer event as the block should report it.
  typedef struct {
    event_kind_e kind;
    logic [7:0]  data;
    logic        msg_end;
    logic [15:0] total;
  } deframe_event_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i   = '0;
  logic        chunk_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [7:0]  out_byte_o;
  logic        message_end_o;
  logic [15:0] ack_total_o;

  mqtt_inbound_packet_deframer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .chunk_end_i   (chunk_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .out_byte_o    (out_byte_o),
    .message_end_o (message_end_o),
    .ack_total_o   (ack_total_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bytes waiting to be offered, and events predicted but not yet seen.
  rx_item_t       rx_feed[$];
  deframe_event_t expected_events[$];

  // Idle rates in percent; changed only while everything is drained.
  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 72;

  int unsigned fed_total       = 0;
  int unsigned bytes_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned kind_seen [8]   = '{default: 0};

  // ---------------------------------------------------------------------------
  // Deframer prediction: a private copy of the parser state, stepped once per
  // accepted byte. Reset state is the declaration value; reset happens once.
  // ---------------------------------------------------------------------------
  phase_e      ph          = PhIdle;
  logic [27:0] len_acc     = '0;   // decoded remaining length
  logic [2:0]  len_idx     = '0;   // length bytes seen so far
  logic [27:0] left_bytes  = '0;   // payload bytes still to come
  logic [15:0] topic_left  = '0;
  logic [2:0]  ack_left    = '0;
  ack_kind_e   ack_kind    = AckConnack;
  logic [15:0] ack_tally [3] = '{default: '0};

  task automatic note_event(input event_kind_e k, input logic [7:0] d, input logic e,
                            input logic [15:0] t);
    deframe_event_t ev;
    ev.kind    = k;
    ev.data    = d;
    ev.msg_end = e;
    ev.total   = t;
    expected_events.push_back(ev);
  endtask

  // Error event; a chunk end on the error byte itself skips the drop state.
  task automatic enter_error(input event_kind_e k, input logic ce);
    ph = ce ? PhIdle : PhDrop;
    note_event(k, 8'h00, 1'b0, 16'h0000);
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic ce);
    event_kind_e ack_ev;
    case (ph)
      PhLen: begin
        // 7 bits per length byte; continuation bit of the 4th byte is ignored
        len_acc = len_acc + (28'(b[6:0]) << (7 * len_idx[1:0]));
        len_idx = len_idx + 3'd1;
        if (!b[7] || len_idx >= 3'd4) ph = PhThi;
      end
      PhThi: begin
        topic_left = {b, 8'h00};
        ph = PhTlo;
      end
      PhTlo: begin
        topic_left[7:0] = b;
        // topic length field plus packet id must fit in the remaining length
        if (29'(topic_left) + 29'(PidBytes) > 29'(len_acc)) begin
          enter_error(EvMalformed, ce);
        end else begin
          left_bytes = len_acc - PidBytes - 28'(topic_left);
          ph = (topic_left != 16'h0000) ? PhTopic : PhPidh;
        end
      end
      PhTopic: begin
        topic_left = topic_left - 16'd1;
        if (topic_left == 16'h0000) ph = PhPidh;
        note_event(EvTopic, b, topic_left == 16'h0000 && left_bytes == '0, 16'h0000);
      end
      PhPidh: ph = PhPidl;
      PhPidl: begin
        if (left_bytes != '0) begin
          ph = PhPay;
        end else begin
          ph = PhIdle;
          // only a publish with neither topic nor payload reports here
          if (len_acc == PidBytes) note_event(EvEmpty, 8'h00, 1'b1, 16'h0000);
        end
      end
      PhPay: begin
        left_bytes = left_bytes - 28'd1;
        if (left_bytes == '0) ph = PhIdle;
        note_event(EvPayload, b, left_bytes == '0, 16'h0000);
      end
      PhAck: begin
        ack_left = ack_left - 3'd1;
        if (ack_left == 3'd0) begin
          ph = PhIdle;
          ack_tally[ack_kind] = ack_tally[ack_kind] + 16'd1;
          if (ack_kind == AckConnack) begin
            ack_ev = EvConnack;
          end else if (ack_kind == AckSuback) begin
            ack_ev = EvSuback;
          end else begin
            ack_ev = EvPuback;
          end
          note_event(ack_ev, 8'h00, 1'b0, ack_tally[ack_kind]);
        end
      end
      PhDrop: begin
        if (ce) ph = PhIdle;
      end
      default: begin
        if (b[7:4] == PublishType) begin
          len_acc = '0;
          len_idx = '0;
          ph = PhLen;
        end else if (b == ConnackByte || b == SubackByte || b == PubackByte) begin
          if (b == ConnackByte) begin
            ack_kind = AckConnack;
          end else if (b == SubackByte) begin
            ack_kind = AckSuback;
          end else begin
            ack_kind = AckPuback;
          end
          ack_left = (b == SubackByte) ? 3'd4 : 3'd3;
          ph = PhAck;
        end else begin
          enter_error(EvUnparsable, ce);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts each one on its transfer.
  // Valid holds with a stable payload until the transfer.
  // ---------------------------------------------------------------------------
  rx_item_t next_rx;

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      deframe_byte(rx_byte_i, chunk_end_i);
      bytes_accepted++;
    end
    if (!in_valid_i || in_ready_o) begin
      if (rst_ni && rx_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_rx = rx_feed.pop_front();
        in_valid_i  <= 1'b1;
        rx_byte_i   <= next_rx.data;
        chunk_end_i <= next_rx.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each result transfer checked in order.
  // ---------------------------------------------------------------------------
  deframe_event_t want;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %h end %b total %0d",
                   event_kind_o, out_byte_o, message_end_o, ack_total_o);
      end else begin
        want = expected_events.pop_front();
        if (event_kind_o !== want.kind || out_byte_o !== want.data ||
            message_end_o !== want.msg_end || ack_total_o !== want.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected kind %0d byte %h end %b total %0d,",
                     results_checked, want.kind, want.data, want.msg_end, want.total,
                     " got kind %0d byte %h end %b total %0d",
                     event_kind_o, out_byte_o, message_end_o, ack_total_o);
        end
        results_checked++;
        kind_seen[event_kind_o]++;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------
  task automatic feed(input logic [7:0] b, input logic ce);
    rx_item_t it;
    it.data = b;
    it.last = ce;
    rx_feed.push_back(it);
    fed_total++;
  endtask

  // chunk ends inside packets are ignored by the block
  function automatic logic stray_end();
    return ($urandom_range(15) == 0);
  endfunction

  // Random bytes up to a byte that closes the chunk.
  task automatic feed_to_chunk_end();
    repeat ($urandom_range(5)) feed(8'($urandom), 1'b0);
    feed(8'($urandom), 1'b1);
  endtask

  // PUBLISH; pad may give a non-minimal length encoding, cut_short stops it
  // somewhere after the length bytes.
  task automatic feed_publish(input int unsigned topic_n, input int unsigned pay_n,
                              input bit pad, input bit cut_short);
    logic [7:0]  pkt[$];
    int unsigned rem;
    int unsigned nlen;
    int unsigned keep;
    logic [7:0]  lb;
    rem  = topic_n + pay_n + 4;
    nlen = (rem < 128) ? 1 : (rem < 16384) ? 2 : (rem < 2097152) ? 3 : 4;
    if (pad) nlen = $urandom_range(4, nlen);
    pkt.push_back({PublishType, 4'($urandom)});
    for (int i = 0; i < nlen; i++) begin
      lb = 8'((rem >> (7 * i)) & 32'h7F);
      if (i < nlen - 1) begin
        lb = lb | LenContFlag;
      end else if (i == 3) begin
        lb[7] = 1'($urandom);
      end
      pkt.push_back(lb);
    end
    pkt.push_back(8'(topic_n >> 8));
    pkt.push_back(8'(topic_n));
    repeat (topic_n) pkt.push_back(8'($urandom));
    repeat (2) pkt.push_back(8'($urandom));
    repeat (pay_n) pkt.push_back(8'($urandom));
    keep = pkt.size();
    if (cut_short) keep = $urandom_range(pkt.size() - 1, nlen + 1);
    for (int i = 0; i < keep; i++) feed(pkt[i], stray_end());
  endtask

  task automatic feed_ack(input logic [7:0] first);
    feed(first, stray_end());
    repeat ((first == SubackByte) ? 4 : 3) feed(8'($urandom), stray_end());
  endtask

  // Topic length that cannot fit, remaining length possibly below 4.
  task automatic feed_malformed();
    int unsigned rl;
    int unsigned tl;
    logic        ce;
    rl = $urandom_range(20);
    tl = $urandom_range(65535, (rl < 4) ? 0 : rl - 3);
    ce = ($urandom_range(2) == 0);
    feed({PublishType, 4'($urandom)}, stray_end());
    feed(8'(rl), stray_end());
    feed(8'(tl >> 8), stray_end());
    feed(8'(tl), ce);
    if (!ce) feed_to_chunk_end();
  endtask

  task automatic feed_unknown();
    logic [7:0] b;
    logic       ce;
    do b = 8'($urandom);
    while (b[7:4] == PublishType || b == ConnackByte || b == SubackByte || b == PubackByte);
    ce = ($urandom_range(2) == 0);
    feed(b, ce);
    if (!ce) feed_to_chunk_end();
  endtask

  // Loose bytes; no publish headers, so a noise burst cannot open a huge packet.
  task automatic feed_noise();
    logic [7:0] b;
    repeat ($urandom_range(6, 1)) begin
      b = 8'($urandom);
      if (b[7:4] == PublishType) b[4] = 1'b0;
      feed(b, $urandom_range(2) == 0);
    end
  endtask

  // Mostly well-formed packets with random content, some errors and noise.
  task automatic feed_random_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int unsigned topic_n;
    int unsigned pay_n;
    start = fed_total;
    while (fed_total - start < n_bytes) begin
      pick    = $urandom_range(99);
      topic_n = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(6);
      pay_n   = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(12);
      if (pick < 55) begin
        feed_publish(topic_n, pay_n, $urandom_range(3) == 0, 1'b0);
      end else if (pick < 67) begin
        case ($urandom_range(2))
          0:       feed_ack(ConnackByte);
          1:       feed_ack(SubackByte);
          default: feed_ack(PubackByte);
        endcase
      end else if (pick < 74) begin
        feed_malformed();
      end else if (pick < 80) begin
        feed_unknown();
      end else if (pick < 88) begin
        feed_noise();
      end else begin
        feed_publish(topic_n, pay_n, $urandom_range(3) == 0, 1'b1);
      end
    end
  endtask

  // Sender holds off until every predicted event has been seen, then keeps
  // waiting so that bytes that give no result are through as well.
  task automatic drain();
    do @(negedge clk_i);
    while (rx_feed.size() != 0 || in_valid_i || expected_events.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // minimal publish: no topic, no payload
    feed({PublishType, 4'h0}, 1'b0);
    feed(8'h04, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'hA5, 1'b0);
    feed(8'h5A, 1'b1);
    // one topic byte, empty payload: the topic byte closes the message
    feed({PublishType, 4'hF}, 1'b0);
    feed(8'h05, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h01, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h00, 1'b0);
    feed_ack(ConnackByte);
    feed_ack(SubackByte);
    feed_ack(PubackByte);
    // unknown first byte that also ends the chunk
    feed(8'hFF, 1'b1);
    // largest topic length against a remaining length of 2
    feed({PublishType, 4'h0}, 1'b0);
    feed(8'h02, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b1);
    // four length bytes, continuation set on the last one, value 4
    feed({PublishType, 4'h1}, 1'b0);
    feed(8'h84, 1'b0);
    feed(8'h80, 1'b0);
    feed(8'h80, 1'b0);
    feed(8'h80, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h12, 1'b0);
    feed(8'h34, 1'b0);
    drain();

    feed_random_traffic(530);
    drain();

    send_idle_pct = 72;
    recv_idle_pct = 33;
    feed_random_traffic(530);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    feed_random_traffic(530);
    // largest remaining length, 2^28-1; stays in the payload from here on
    feed({PublishType, 4'h0}, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'hFF, 1'b0);
    feed(8'h7F, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'h00, 1'b0);
    feed(8'($urandom), 1'b0);
    feed(8'($urandom), 1'b0);
    repeat (24) feed(8'($urandom), stray_end());
    drain();

    if (expected_events.size() != 0) begin
      $display("%0d predicted events never arrived", expected_events.size());
      mismatches += expected_events.size();
    end
    $display("covered %0d bytes and %0d checked results over three idle mixes",
             bytes_accepted, results_checked);
    $display("by kind: topic %0d payload %0d empty %0d acks %0d/%0d/%0d errors %0d/%0d",
             kind_seen[EvTopic], kind_seen[EvPayload], kind_seen[EvEmpty],
             kind_seen[EvConnack], kind_seen[EvSuback], kind_seen[EvPuback],
             kind_seen[EvUnparsable], kind_seen[EvMalformed]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("watchdog expired with %0d events outstanding", expected_events.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
